FILE: src/fft_pkg.sv
// Shared types and constants for the forward fairness priority tracker.
// No dependencies; used by every module under src.
package fft_pkg;

    localparam int NUM_UNITS   = 32;
    localparam int UNIT_IDX_W  = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int UNIT_ID_W   = 5;
    localparam int UCNT_W      = 3;
    localparam int TOTAL_W     = 8;
    localparam int WINDOW_W    = 6;
    localparam int LFSR_W      = 9;
    localparam int DITHER_W    = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [UCNT_W-1:0]   UCNT_MAX     = 3'd7;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd1;

    typedef struct packed {
        logic                 forward_ack;
        logic [UNIT_ID_W-1:0] unit_id;
        logic                 is_chain;
        logic                 local_issued;
    } fft_item_t;

    // Held request handed from the input register to the tracker
    typedef struct packed {
        logic      valid;
        fft_item_t item;
    } fft_req_t;

endpackage

FILE: src/fft_in_stage.sv
// Input register for tracker requests: unpacks the stream payload and holds it.
// Depends on fft_pkg.
module fft_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fft_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          advance,
    output fft_pkg::fft_req_t             req
);

    logic              valid_reg;
    fft_pkg::fft_item_t item_reg;
    fft_pkg::fft_item_t item_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        item_next.forward_ack  = s_tdata[0];
        item_next.unit_id      = s_tdata[fft_pkg::UNIT_ID_W:1];
        item_next.local_issued = s_tdata[fft_pkg::UNIT_ID_W+1];
        item_next.is_chain     = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign req.valid = valid_reg;
    assign req.item  = item_reg;

endmodule

FILE: src/fft_tracker.sv
// Fairness state: per-unit counters, forward total, denominator, window, LFSR, priority.
// Depends on fft_pkg.
module fft_tracker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [fft_pkg::LFSR_W-1:0] cfg_wr_data,
    input  fft_pkg::fft_req_t          req,
    input  logic                       advance,
    output logic                       priority_next
);

    logic [fft_pkg::UCNT_W-1:0]   ucnt_reg [fft_pkg::NUM_UNITS];
    logic [fft_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [fft_pkg::TOTAL_W-1:0]  denom_reg, denom_next;
    logic [fft_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [fft_pkg::LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic                         prio_reg, prio_next;

    logic                           counted, bump, overflow, low;
    logic [fft_pkg::UNIT_IDX_W-1:0] uidx;
    logic [fft_pkg::UCNT_W-1:0]     ucnt_sel;
    logic [fft_pkg::LFSR_W-1:0]     reload_sum;

    always_comb begin
        uidx     = req.item.unit_id[fft_pkg::UNIT_IDX_W-1:0];
        ucnt_sel = ucnt_reg[uidx];
        counted  = req.item.forward_ack && !req.item.is_chain;
        bump     = counted && ({1'b0, req.item.unit_id} <
                   (fft_pkg::UNIT_ID_W+1)'(fft_pkg::NUM_UNITS));
        overflow = bump && (ucnt_sel == fft_pkg::UCNT_MAX);
        low      = (window_reg <= fft_pkg::WINDOW_W'(1));

        total_next = total_reg;
        denom_next = denom_reg;
        if (overflow) begin
            denom_next = total_reg + fft_pkg::TOTAL_W'(1);
            total_next = '0;
        end else if (req.item.forward_ack) begin
            total_next = total_reg + fft_pkg::TOTAL_W'(1);
        end

        // Reload quotient may reach 65; keep it modulo 64
        reload_sum  = {1'b0, denom_reg} + fft_pkg::LFSR_W'(lfsr_reg[fft_pkg::DITHER_W-1:0]);
        window_next = window_reg;
        if (req.item.forward_ack) begin
            if (low) begin
                window_next = reload_sum[fft_pkg::WINDOW_W+1:2];
            end else begin
                window_next = window_reg - fft_pkg::WINDOW_W'(1);
            end
        end

        lfsr_next = lfsr_reg;
        prio_next = prio_reg;
        if (counted && low) begin
            lfsr_next = {lfsr_reg[0] ^ lfsr_reg[4], lfsr_reg[fft_pkg::LFSR_W-1:1]};
            prio_next = 1'b1;
        end else if (req.item.local_issued) begin
            prio_next = 1'b0;
        end
    end

    assign priority_next = prio_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fft_pkg::NUM_UNITS; i++) begin
                ucnt_reg[i] <= '0;
            end
            total_reg  <= '0;
            denom_reg  <= '0;
            window_reg <= fft_pkg::WINDOW_RESET;
            lfsr_reg   <= '0;
            prio_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lfsr_reg <= cfg_wr_data;
            end else if (advance) begin
                lfsr_reg <= lfsr_next;
            end
            if (advance) begin
                for (int i = 0; i < fft_pkg::NUM_UNITS; i++) begin
                    if (overflow) begin
                        ucnt_reg[i] <= '0;
                    end else if (bump && (uidx == fft_pkg::UNIT_IDX_W'(i))) begin
                        ucnt_reg[i] <= ucnt_reg[i] + fft_pkg::UCNT_W'(1);
                    end
                end
                total_reg  <= total_next;
                denom_reg  <= denom_next;
                window_reg <= window_next;
                prio_reg   <= prio_next;
            end
        end
    end

endmodule

FILE: src/forward_fairness_priority_tracker_core.sv
// Top level of the forward fairness priority tracker: input register, tracker, result register.
// Depends on fft_pkg, fft_in_stage and fft_tracker.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata, s_tuser (is_chain)
//  m_      | out | m_tvalid/m_tready | m_tdata (prio_out)
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data (lfsr_seed, also loads the LFSR)
//
// One request per cycle while m_tready is high; input register first, then result register.
// The state update sits between the input register and the result register.
// Reset is synchronous on aresetn low; the LFSR comes out of reset at zero.
// A stall on m_tready holds the result; a full input register holds in the same
// cycle and drops s_tready, an empty one takes one more request first.
module forward_fairness_priority_tracker_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] forward_ack, [5:1] unit_id, [6] local_issued, [7] zero
    input  logic [fft_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] is_chain
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] prio_out, [7:1] zero
    output logic [fft_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [fft_pkg::LFSR_W-1:0]    cfg_wr_data
);

    fft_pkg::fft_req_t req;
    logic              advance;
    logic              priority_next;
    logic              m_valid_reg;
    logic              m_prio_reg;

    assign advance = req.valid && (!m_valid_reg || m_tready);

    fft_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .req      (req)
    );

    fft_tracker u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req),
        .advance       (advance),
        .priority_next (priority_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= req.valid;
        end
        if (advance) begin
            m_prio_reg <= priority_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(fft_pkg::M_TDATA_W-1)'(0), m_prio_reg};

endmodule

FILE: sim/fft_checker.sv
`timescale 1ns / 100ps
// Checker for the forward fairness priority tracker: watches the request, result and
// config channels, predicts prio_out per request and compares. Depends on fft_pkg.
module fft_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fft_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fft_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [fft_pkg::LFSR_W-1:0]    cfg_wr_data,
    output int                            error_count,
    output int                            outstanding
);
    import fft_pkg::*;

    logic [UCNT_W-1:0]   unit_cnt [NUM_UNITS];
    logic [TOTAL_W-1:0]  fwd_total;
    logic [TOTAL_W-1:0]  denom;
    logic [WINDOW_W-1:0] window;
    logic [LFSR_W-1:0]   lfsr;
    logic                prio_flag;
    logic                prio_expected [$];
    int                  errs = 0;

    // Advance the tracker state by one request and return the new priority bit.
    function automatic logic next_priority(input fft_item_t req);
        logic             counted;
        logic             bump;
        logic             wrap;
        logic             low;
        logic [TOTAL_W:0] reload;
        counted = req.forward_ack && !req.is_chain;
        bump    = counted && (int'(req.unit_id) < NUM_UNITS);
        wrap    = bump && (unit_cnt[req.unit_id] == UCNT_MAX);
        low     = (window <= 1);
        reload  = {1'b0, denom} + (TOTAL_W+1)'(lfsr[DITHER_W-1:0]);
        if (wrap) begin
            foreach (unit_cnt[u]) unit_cnt[u] = '0;
            denom     = fwd_total + 1'b1;
            fwd_total = '0;
        end else begin
            if (bump) unit_cnt[req.unit_id] = unit_cnt[req.unit_id] + 1'b1;
            if (req.forward_ack) fwd_total = fwd_total + 1'b1;
        end
        // quotient may reach 65; keep it modulo 64
        if (req.forward_ack) window = low ? reload[WINDOW_W+1:2] : window - 1'b1;
        if (counted && low) begin
            lfsr      = {lfsr[0] ^ lfsr[4], lfsr[LFSR_W-1:1]};
            prio_flag = 1'b1;
        end else if (req.local_issued) begin
            prio_flag = 1'b0;
        end
        return prio_flag;
    endfunction

    always @(posedge aclk) begin : monitor
        fft_item_t req;
        logic      want;
        if (!aresetn) begin
            foreach (unit_cnt[u]) unit_cnt[u] = '0;
            fwd_total = '0;
            denom     = '0;
            window    = WINDOW_RESET;
            lfsr      = '0;
            prio_flag = 1'b0;
            prio_expected.delete();
        end else begin
            if (cfg_wr_en) lfsr = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (prio_expected.size() == 0) begin
                    $error("prio_out: expected none, actual %0d", m_tdata[0]);
                    errs++;
                end else begin
                    want = prio_expected.pop_front();
                    if (m_tdata[0] !== want) begin
                        $error("prio_out: expected %0d, actual %0d", want, m_tdata[0]);
                        errs++;
                    end
                end
                if (m_tdata[M_TDATA_W-1:1] !== '0) begin
                    $error("m_tdata padding: expected 0, actual %0h", m_tdata[M_TDATA_W-1:1]);
                    errs++;
                end
            end
            if (s_tvalid && s_tready) begin
                req.forward_ack  = s_tdata[0];
                req.unit_id      = s_tdata[UNIT_ID_W:1];
                req.local_issued = s_tdata[UNIT_ID_W+1];
                req.is_chain     = s_tuser;
                prio_expected.push_back(next_priority(req));
            end
        end
        outstanding <= prio_expected.size();
        error_count <= errs;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the tracker testbench: clock, reset, request and config stimulus, verdict.
// Depends on fft_pkg, forward_fairness_priority_tracker_core and fft_checker.
module tb_top;
    import fft_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 58;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [LFSR_W-1:0]    cfg_wr_data;
    int                   error_count;
    int                   outstanding;
    int                   idle_pct  = 0;
    int                   stall_pct = 0;

    forward_fairness_priority_tracker_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    fft_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    function automatic fft_item_t make_req(input logic ack, input logic [UNIT_ID_W-1:0] uid,
                                           input logic chain, input logic issued);
        fft_item_t req;
        req.forward_ack  = ack;
        req.unit_id      = uid;
        req.is_chain     = chain;
        req.local_issued = issued;
        return req;
    endfunction

    // Half the traffic goes to one unit so its counter overflows often.
    function automatic fft_item_t random_req(input logic [UNIT_ID_W-1:0] hot);
        fft_item_t req;
        logic [UNIT_ID_W-1:0] any_unit;
        any_unit         = UNIT_ID_W'($urandom_range(NUM_UNITS - 1));
        req.forward_ack  = ($urandom_range(3) != 0);
        req.unit_id      = $urandom_range(1) ? hot : any_unit;
        req.is_chain     = ($urandom_range(3) == 0);
        req.local_issued = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic send_req(input fft_item_t req);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, req.local_issued, req.unit_id, req.forward_ack};
        s_tuser  <= req.is_chain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [LFSR_W-1:0] seed);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [LFSR_W-1:0]    seeds [PHASES];
        logic [UNIT_ID_W-1:0] hot_unit;
        int                   n_chain;
        seeds = '{9'h1FF, 9'h001, 9'h000, 9'h0A5, 9'h100, 9'h000, 9'h000, 9'h1FF};
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, LFSR at zero after reset
        send_req(make_req(1'b0, 5'd0, 1'b0, 1'b0));
        // acknowledge and local issue together: set wins
        send_req(make_req(1'b1, 5'd31, 1'b0, 1'b1));
        send_req(make_req(1'b0, 5'd0, 1'b0, 1'b1));
        send_req(make_req(1'b1, 5'd0, 1'b1, 1'b0));
        // eighth bump on unit 31 overflows and latches the denominator
        repeat (8) send_req(make_req(1'b1, 5'd31, 1'b0, 1'b0));
        send_req(make_req(1'b0, 5'd31, 1'b1, 1'b1));
        for (int k = 0; k < 6; k++) send_req(make_req(1'b1, 5'd0, 1'b0, k[0]));
        send_req(make_req(1'b1, 5'd21, 1'b1, 1'b1));
        send_req(make_req(1'b1, 5'd10, 1'b0, 1'b0));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph == 3 || ph == 5 || ph == 6) seeds[ph] = LFSR_W'($urandom_range(511));
            write_seed(seeds[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            hot_unit = UNIT_ID_W'($urandom_range(NUM_UNITS - 1));
            if (ph == 0) begin
                // long chain run pushes the forward total near or past its wrap,
                // then force an overflow to latch it as the denominator
                n_chain = $urandom_range(270, 240);
                repeat (n_chain)
                    send_req(make_req(1'b1, UNIT_ID_W'($urandom_range(31)), 1'b1,
                                      1'($urandom_range(1))));
                repeat (8) send_req(make_req(1'b1, hot_unit, 1'b0, 1'b0));
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (k % 16 == 15) hot_unit = UNIT_ID_W'($urandom_range(NUM_UNITS - 1));
                send_req(random_req(hot_unit));
            end
        end
        wait_drained();

        if (error_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
